[sv/x86d_pkg.sv]
// Package of the 8086 decoder: types, codes, tables and decode functions.
`default_nettype none

package x86d_pkg;

  // Opcode classes.
  typedef enum logic [3:0] {
    K_UNK,
    K_JMP,
    K_MOVRM,
    K_SEG,
    K_MOVIRM,
    K_MOVIREG,
    K_MOVACC,
    K_GRP1,
    K_ARITH_RM,
    K_ARITH_ACC
  } kind_e;

  // Mnemonic codes.
  localparam logic [4:0] MN_MOV    = 5'd0;
  localparam logic [4:0] MN_ADD    = 5'd3;
  localparam logic [4:0] MN_SUB    = 5'd4;
  localparam logic [4:0] MN_CMP    = 5'd5;
  localparam logic [4:0] MN_JNZ    = 5'd6;
  localparam logic [4:0] MN_LOOPNZ = 5'd26;

  // Operand form codes.
  localparam logic [3:0] FORM_REG_REG    = 4'd0;
  localparam logic [3:0] FORM_REG_TO_MEM = 4'd1;
  localparam logic [3:0] FORM_MEM_TO_REG = 4'd2;
  localparam logic [3:0] FORM_IMM_TO_REG = 4'd3;
  localparam logic [3:0] FORM_IMM_TO_MEM = 4'd4;
  localparam logic [3:0] FORM_IMM_TO_ACC = 4'd5;
  localparam logic [3:0] FORM_MEM_TO_ACC = 4'd6;
  localparam logic [3:0] FORM_ACC_TO_MEM = 4'd7;
  localparam logic [3:0] FORM_JUMP       = 4'd8;
  localparam logic [3:0] FORM_UNKNOWN    = 4'd9;

  // Mnemonic of the short conditional jumps 70..7F, by low opcode nibble.
  localparam logic [4:0] JCC_MNEM [16] = '{
    5'd15, 5'd19, 5'd12, 5'd21, 5'd7, 5'd6, 5'd13, 5'd22,
    5'd16, 5'd20, 5'd14, 5'd18, 5'd8, 5'd11, 5'd9, 5'd10
  };

  // One decoded instruction.
  typedef struct packed {
    logic [4:0]  mnemonic;
    logic [3:0]  form;
    logic        wide;
    logic [2:0]  reg_code;
    logic [2:0]  rm_code;
    logic [1:0]  mode_code;
    logic        direct_address;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  length;
    logic        unsupported;
  } rec_t;

  // True when bits 5:3 select add, sub or cmp.
  function automatic logic arith_ok(input logic [7:0] v);
    return (v[5:3] == 3'd0) || (v[5:3] == 3'd5) || (v[5:3] == 3'd7);
  endfunction

  function automatic logic [4:0] arith_mnem(input logic [7:0] v);
    logic [4:0] mn;
    case (v[5:3])
      3'd0:    mn = MN_ADD;
      3'd5:    mn = MN_SUB;
      3'd7:    mn = MN_CMP;
      default: mn = MN_MOV;
    endcase
    return mn;
  endfunction

  function automatic kind_e classify(input logic [7:0] op);
    kind_e k;
    k = K_UNK;
    if (op[7:4] == 4'h7 || op[7:2] == 6'b111000) begin
      k = K_JMP;
    end else if (op[7:2] == 6'b100010) begin
      k = K_MOVRM;
    end else if (op == 8'h8C || op == 8'h8E) begin
      k = K_SEG;
    end else if (op[7:1] == 7'b1100011) begin
      k = K_MOVIRM;
    end else if (op[7:4] == 4'hB) begin
      k = K_MOVIREG;
    end else if (op[7:2] == 6'b101000) begin
      k = K_MOVACC;
    end else if (op[7:2] == 6'b100000) begin
      k = K_GRP1;
    end else if (op[7:6] == 2'b00 && arith_ok(op)) begin
      if (!op[2]) begin
        k = K_ARITH_RM;
      end else if (op[2:1] == 2'b10) begin
        k = K_ARITH_ACC;
      end
    end
    return k;
  endfunction

  function automatic logic has_modrm(input kind_e k);
    return (k == K_MOVRM) || (k == K_SEG) || (k == K_MOVIRM) ||
           (k == K_GRP1) || (k == K_ARITH_RM);
  endfunction

  // Number of displacement (or address, or offset) bytes.
  function automatic logic [1:0] disp_len(input kind_e k, input logic [7:0] m);
    logic [1:0] n;
    n = 2'd0;
    if (has_modrm(k)) begin
      case (m[7:6])
        2'd0:    n = (m[2:0] == 3'd6) ? 2'd2 : 2'd0;
        2'd1:    n = 2'd1;
        2'd2:    n = 2'd2;
        default: n = 2'd0;
      endcase
    end else if (k == K_JMP) begin
      n = 2'd1;
    end else if (k == K_MOVACC) begin
      n = 2'd2;
    end
    return n;
  endfunction

  // Number of immediate bytes.
  function automatic logic [1:0] imm_len(input kind_e k, input logic [7:0] op);
    logic [1:0] n;
    n = 2'd0;
    if (k == K_MOVIRM || k == K_ARITH_ACC) begin
      n = {1'b0, 1'b1} + {1'b0, op[0]};
    end else if (k == K_GRP1) begin
      n = (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
    end else if (k == K_MOVIREG) begin
      n = {1'b0, 1'b1} + {1'b0, op[3]};
    end
    return n;
  endfunction

  function automatic logic [2:0] total_len(input kind_e k, input logic [7:0] op,
                                           input logic [7:0] m);
    return 3'd1 + {2'b00, has_modrm(k)} + {1'b0, disp_len(k, m)} +
           {1'b0, imm_len(k, op)};
  endfunction

  function automatic logic [15:0] sx8(input logic [15:0] v);
    return {{8{v[7]}}, v[7:0]};
  endfunction

  function automatic rec_t unknown_record(input logic [2:0] len);
    rec_t r;
    r = '0;
    r.form   = FORM_UNKNOWN;
    r.length = len;
    return r;
  endfunction

  // Builds the record of a complete instruction from the gathered bytes.
  function automatic rec_t build_record(input logic [7:0] op, input logic [7:0] m,
                                        input logic [15:0] disp, input logic [15:0] imm,
                                        input logic [2:0] cnt);
    rec_t  r;
    kind_e k;
    logic  mem_op;
    k      = classify(op);
    mem_op = (m[7:6] != 2'd3);
    r      = '0;
    r.wide = op[0];
    r.displacement = (disp_len(k, m) == 2'd1) ? sx8(disp) : disp;
    r.immediate    = (imm_len(k, op) == 2'd1) ? sx8(imm) : imm;
    r.length       = cnt;
    if (has_modrm(k)) begin
      r.reg_code       = m[5:3];
      r.rm_code        = m[2:0];
      r.mode_code      = m[7:6];
      r.direct_address = (m[7:6] == 2'd0) && (m[2:0] == 3'd6);
    end
    case (k)
      K_JMP: begin
        r.mnemonic = (op[7:4] == 4'h7) ? JCC_MNEM[op[3:0]] : MN_LOOPNZ - {3'b000, op[1:0]};
        r.form     = FORM_JUMP;
        r.wide     = 1'b0;
      end
      K_MOVRM, K_SEG, K_ARITH_RM: begin
        r.mnemonic = (k == K_ARITH_RM) ? arith_mnem(op) : MN_MOV;
        r.form     = !mem_op ? FORM_REG_REG : (op[1] ? FORM_MEM_TO_REG : FORM_REG_TO_MEM);
        if (k == K_SEG) begin
          r.wide        = 1'b1;
          r.unsupported = 1'b1;
        end
      end
      K_MOVIRM, K_GRP1: begin
        r.mnemonic = (k == K_GRP1) ? arith_mnem(m) : MN_MOV;
        r.form     = mem_op ? FORM_IMM_TO_MEM : FORM_IMM_TO_REG;
      end
      K_MOVIREG: begin
        r.form     = FORM_IMM_TO_REG;
        r.wide     = op[3];
        r.reg_code = op[2:0];
      end
      K_MOVACC: begin
        r.form           = op[1] ? FORM_ACC_TO_MEM : FORM_MEM_TO_ACC;
        r.direct_address = 1'b1;
      end
      default: begin
        r.mnemonic = arith_mnem(op);
        r.form     = FORM_IMM_TO_ACC;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/x86d_core.sv]
// Decode sequencer: phase and gathered bytes, builds a record on the last byte.
`default_nettype none

module x86d_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    code_byte_i,
  output logic               res_valid_o,
  output x86d_pkg::rec_t     res_o
);
  import x86d_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MODRM = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [15:0] disp_q, disp_d;
  logic [15:0] imm_q, imm_d;
  logic [2:0]  count_q, count_d;

  kind_e      k_hold, k_byte;
  logic [2:0] base;
  logic [2:0] pos;
  logic [2:0] imm_pos;
  logic [1:0] dl;
  logic [15:0] lane;

  always_comb begin
    k_hold  = classify(opcode_q);
    k_byte  = classify(code_byte_i);
    base    = 3'd1 + {2'b00, has_modrm(k_hold)};
    dl      = disp_len(k_hold, modrm_q);
    pos     = count_q - base;
    imm_pos = pos - {1'b0, dl};
    lane    = {8'h00, code_byte_i};

    phase_d     = phase_q;
    opcode_d    = opcode_q;
    modrm_d     = modrm_q;
    disp_d      = disp_q;
    imm_d       = imm_q;
    count_d     = count_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i) begin
      case (phase_q)
        PH_MODRM: begin
          modrm_d = code_byte_i;
          count_d = 3'd2;
          if (k_hold == K_GRP1 && !arith_ok(code_byte_i)) begin
            // Undefined group-1 operation: the modrm byte goes with it.
            phase_d     = PH_IDLE;
            res_valid_o = 1'b1;
            res_o       = unknown_record(3'd2);
          end else if (total_len(k_hold, opcode_q, code_byte_i) <= 3'd2) begin
            phase_d     = PH_IDLE;
            res_valid_o = 1'b1;
            res_o       = build_record(opcode_q, code_byte_i, disp_q, imm_q, 3'd2);
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if (pos < {1'b0, dl}) begin
            disp_d = disp_q | (pos[0] ? {code_byte_i, 8'h00} : lane);
          end else begin
            imm_d = imm_q | (imm_pos[0] ? {code_byte_i, 8'h00} : lane);
          end
          count_d = count_q + 3'd1;
          if (count_d >= total_len(k_hold, opcode_q, modrm_q)) begin
            phase_d     = PH_IDLE;
            res_valid_o = 1'b1;
            res_o       = build_record(opcode_q, modrm_q, disp_d, imm_d, count_d);
          end
        end
        default: begin
          opcode_d = code_byte_i;
          modrm_d  = 8'h00;
          disp_d   = 16'h0000;
          imm_d    = 16'h0000;
          count_d  = 3'd1;
          if (k_byte == K_UNK) begin
            phase_d     = PH_IDLE;
            res_valid_o = 1'b1;
            res_o       = unknown_record(3'd1);
          end else begin
            phase_d = has_modrm(k_byte) ? PH_MODRM : PH_DATA;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      opcode_q <= 8'h00;
      modrm_q  <= 8'h00;
      disp_q   <= 16'h0000;
      imm_q    <= 16'h0000;
      count_q  <= 3'd0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      modrm_q  <= modrm_d;
      disp_q   <= disp_d;
      imm_q    <= imm_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

[sv/x86d_outbuf.sv]
// Result register with a skid stage between the decoder and the output channel.
`default_nettype none

module x86d_outbuf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire x86d_pkg::rec_t rec_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output x86d_pkg::rec_t     out_rec_o
);
  import x86d_pkg::*;

  logic out_valid_q, skid_valid_q;
  rec_t out_q, skid_q;
  logic pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= rec_i;
      end else begin
        skid_q <= rec_i;
      end
    end
  end

endmodule

`default_nettype wire

[sv/x86_16bit_instruction_decoder_top.sv]
// Top level of the byte-serial 8086 instruction decoder.
//
// The decoder takes an 8086 code stream one byte per transfer on the input
// channel (in_valid_i, in_stall_o, code_byte_i). It keeps the decode phase,
// the opcode, the modrm byte and the displacement and immediate bytes seen
// so far. On the last byte of every instruction it produces one decoded
// record on the output channel (out_valid_o, out_stall_i and the field
// ports); all other bytes produce nothing. Unknown opcodes, and group-1
// opcodes with an undefined operation field, come out as unknown records.
//
// The record of an instruction is registered on its last byte, into the
// result register or, when the receiver stalls, the skid register. The
// decoder takes one byte per cycle unless in_stall_o is high; decode is a
// single pass of logic from the held state and the byte into a register.
//
// When the receiver stalls, the pending record holds still and a second
// record goes into a skid register; only when that skid register is
// occupied does in_stall_o rise, so bytes keep flowing in a stall until
// the skid register fills. Reset returns the decoder to waiting for an
// opcode and empties both output registers.
`default_nettype none

module x86_16bit_instruction_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  code_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       mnemonic_o,
  output logic [3:0]       form_o,
  output logic             wide_o,
  output logic [2:0]       reg_code_o,
  output logic [2:0]       rm_code_o,
  output logic [1:0]       mode_code_o,
  output logic             direct_address_o,
  output logic signed [15:0] displacement_o,
  output logic signed [15:0] immediate_o,
  output logic [2:0]       length_o,
  output logic             unsupported_o
);
  import x86d_pkg::*;

  logic accept;
  logic res_valid;
  rec_t res;
  rec_t out_rec;
  logic full;

  // A byte is transferred whenever the skid register has room.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  x86d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .code_byte_i (code_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  x86d_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .rec_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rec_o   (out_rec)
  );

  assign mnemonic_o       = out_rec.mnemonic;
  assign form_o           = out_rec.form;
  assign wide_o           = out_rec.wide;
  assign reg_code_o       = out_rec.reg_code;
  assign rm_code_o        = out_rec.rm_code;
  assign mode_code_o      = out_rec.mode_code;
  assign direct_address_o = out_rec.direct_address;
  assign displacement_o   = $signed(out_rec.displacement);
  assign immediate_o      = $signed(out_rec.immediate);
  assign length_o         = out_rec.length;
  assign unsupported_o    = out_rec.unsupported;

endmodule

`default_nettype wire

[sv/x86d_checker.sv]
// Port checker of the 8086 decoder and its bind to the top level.
`default_nettype none

module x86d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [4:0]  mnemonic_o,
  input wire logic [3:0]  form_o,
  input wire logic [2:0]  length_o,
  input wire logic        unsupported_o,
  input wire logic        wide_o
);
  import x86d_pkg::*;

  // A stalled record stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mnemonic_o) &&
      $stable(form_o) && $stable(length_o))
    else $error("stalled output record changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_o >= 3'd1 && length_o <= 3'd6)
    else $error("instruction length out of range");

  // Unknown records are one or two bytes long and carry no mnemonic.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && form_o == FORM_UNKNOWN |->
      mnemonic_o == MN_MOV && (length_o == 3'd1 || length_o == 3'd2))
    else $error("bad unknown record");

  // Short jumps are two bytes and name a jump or loop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && form_o == FORM_JUMP |->
      length_o == 3'd2 && mnemonic_o >= MN_JNZ && mnemonic_o <= MN_LOOPNZ && !wide_o)
    else $error("bad short jump record");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unsupported_o |-> mnemonic_o == MN_MOV && wide_o)
    else $error("bad segment move record");

endmodule

bind x86_16bit_instruction_decoder_top x86d_checker u_x86d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .mnemonic_o    (mnemonic_o),
  .form_o        (form_o),
  .length_o      (length_o),
  .unsupported_o (unsupported_o),
  .wide_o        (wide_o)
);

`default_nettype wire
